// ----- hdl/spc_pkg.sv -----
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants for the self-describing pattern checker.
// ----------------------------------------------------------------------------
package spc_pkg;

  // index arithmetic
  localparam int INDEX_BITS = 22;
  localparam int CNT_W      = INDEX_BITS + 1;

  // port widths
  localparam int DATA_W     = 16;
  localparam int SRC_W      = 15;
  localparam int DISP_W     = 16;
  localparam int OFFSET_W   = 23;
  localparam int COUNT_W    = 23;
  localparam int LIMIT_W    = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);
  localparam logic [SRC_W-1:0]   HALF_SPAN   = SRC_W'(16384);

  // job queue between front and back
  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

  typedef enum logic {
    KIND_MISMATCH = 1'b0,
    KIND_SUMMARY  = 1'b1
  } spc_kind_t;

  // one classified item: what the back has to emit for it
  typedef struct packed {
    logic                  report;
    logic                  last;
    logic [INDEX_BITS-1:0] idx;
    logic [DATA_W-1:0]     got;
    logic [CNT_W-1:0]      err;
    logic [CNT_W-1:0]      pos;
  } spc_job_t;

endpackage

// ----- hdl/spc_front.sv -----
// ----------------------------------------------------------------------------
// spc_front
// Accepts read data, tracks position, mismatch count and reports given,
// and turns each item that needs output into a job for the back end.
// ----------------------------------------------------------------------------
module spc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [spc_pkg::DATA_W-1:0]  read_data,
  input  logic                        first,
  input  logic                        last,
  input  logic                        push,
  output logic                        full,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [spc_pkg::LIMIT_W-1:0] cfg_data,
  output logic                        job_push,
  output spc_pkg::spc_job_t           job,
  input  logic                        job_full
);
  import spc_pkg::*;

  logic [CNT_W-1:0]   position;
  logic [CNT_W-1:0]   error_total;
  logic [LIMIT_W-1:0] reports_given;
  logic [LIMIT_W-1:0] report_limit;

  logic [CNT_W-1:0]   pos0, pos1, err0, err1;
  logic [LIMIT_W-1:0] rg0, rg1;
  logic [INDEX_BITS-1:0] idx;
  logic [DATA_W-1:0]  want;
  logic               mismatch, report, accept;

  assign full      = job_full;
  assign accept    = push && !job_full;
  assign cfg_ready = 1'b1;

  // classify the incoming request
  always_comb begin
    pos0     = first ? '0 : position;
    err0     = first ? '0 : error_total;
    rg0      = first ? '0 : reports_given;
    idx      = pos0[INDEX_BITS-1:0];
    want     = {1'b1, idx[SRC_W-1:0]};
    pos1     = pos0[INDEX_BITS] ? pos0 : pos0 + CNT_W'(1);
    mismatch = (read_data != want);
    err1     = (mismatch && !err0[INDEX_BITS]) ? err0 + CNT_W'(1) : err0;
    report   = mismatch && (rg0 < report_limit);
    rg1      = report ? rg0 + LIMIT_W'(1) : rg0;
  end

  // build the job
  assign job_push   = accept && (report || last);
  assign job.report = report;
  assign job.last   = last;
  assign job.idx    = idx;
  assign job.got    = read_data;
  assign job.err    = err1;
  assign job.pos    = pos1;

  // advance the pass state
  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      error_total   <= '0;
      reports_given <= '0;
    end else if (accept) begin
      position      <= pos1;
      error_total   <= err1;
      reports_given <= rg1;
    end
  end

  // hold the report limit
  always_ff @(posedge clk) begin
    if (rst) begin
      report_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      report_limit <= cfg_data;
    end
  end

`ifndef SYNTHESIS
  a_err_le_pos: assert property (@(posedge clk) disable iff (rst)
    error_total <= position)
    else $error("mismatch count exceeds checked count");
`endif

endmodule

// ----- hdl/spc_jobq.sv -----
// ----------------------------------------------------------------------------
// spc_jobq
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module spc_jobq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  spc_pkg::spc_job_t din,
  output logic              full,
  output logic              valid,
  output spc_pkg::spc_job_t dout,
  input  logic              pop
);
  import spc_pkg::*;

  spc_job_t             entries [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0]   wr_ptr, rd_ptr;
  logic [JOBQ_CW-1:0]   count;
  logic                 do_push, do_pop;

  assign full    = (count == JOBQ_CW'(JOBQ_DEPTH));
  assign valid   = (count != '0);
  assign dout    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // store jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + JOBQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + JOBQ_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + JOBQ_CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - JOBQ_CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= JOBQ_CW'(JOBQ_DEPTH))
    else $error("job queue fill level out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job pushed into a full queue");
`endif

endmodule

// ----- hdl/spc_back.sv -----
// ----------------------------------------------------------------------------
// spc_back
// Expands queued jobs into mismatch reports and pass summaries and holds
// the current result in an output register.
// ----------------------------------------------------------------------------
module spc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_valid,
  input  spc_pkg::spc_job_t            job,
  output logic                         job_pop,
  output logic                         empty,
  input  logic                         pop,
  output logic                         report_kind,
  output logic [spc_pkg::OFFSET_W-1:0] byte_offset,
  output logic [spc_pkg::DATA_W-1:0]   expected,
  output logic [spc_pkg::DATA_W-1:0]   observed,
  output logic                         is_pattern,
  output logic [spc_pkg::SRC_W-1:0]    source_index,
  output logic signed [spc_pkg::DISP_W-1:0] displacement,
  output logic [spc_pkg::COUNT_W-1:0]  mismatch_count,
  output logic [spc_pkg::COUNT_W-1:0]  checked_count,
  output logic                         end_of_run
);
  import spc_pkg::*;

  logic              out_valid;
  logic              phase;        // report of the head job already sent
  logic              load, emit_report, phase_next;
  spc_kind_t         kind_n;
  logic [OFFSET_W-1:0] offset_n;
  logic [DATA_W-1:0] exp_n, obs_n;
  logic              tag_n, end_n;
  logic [SRC_W-1:0]  src_n, delta;
  logic [DISP_W-1:0] disp_n;

  assign empty = !out_valid;
  assign load  = !out_valid || pop;

  // pick the next result from the head job
  always_comb begin
    emit_report = job.report && !phase;
    delta       = job.got[SRC_W-1:0] - job.idx[SRC_W-1:0];
    kind_n      = KIND_SUMMARY;
    offset_n    = '0;
    exp_n       = '0;
    obs_n       = '0;
    tag_n       = 1'b0;
    src_n       = '0;
    disp_n      = '0;
    end_n       = 1'b1;
    job_pop     = 1'b0;
    phase_next  = phase;
    if (emit_report) begin
      kind_n   = KIND_MISMATCH;
      offset_n = OFFSET_W'({job.idx, 1'b0});
      exp_n    = {1'b1, job.idx[SRC_W-1:0]};
      obs_n    = job.got;
      tag_n    = job.got[DATA_W-1];
      end_n    = !job.last;
      if (tag_n) begin
        src_n  = job.got[SRC_W-1:0];
        // wrap the distance into -16383..16384
        disp_n = {(delta > HALF_SPAN), delta};
      end
    end
    if (load && job_valid) begin
      if (emit_report && job.last) begin
        phase_next = 1'b1;
      end else begin
        job_pop    = 1'b1;
        phase_next = 1'b0;
      end
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= job_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && job_valid) begin
      report_kind    <= kind_n;
      byte_offset    <= offset_n;
      expected       <= exp_n;
      observed       <= obs_n;
      is_pattern     <= tag_n;
      source_index   <= src_n;
      displacement   <= disp_n;
      mismatch_count <= COUNT_W'(job.err);
      checked_count  <= COUNT_W'(job.pos);
      end_of_run     <= end_n;
    end
  end

`ifndef SYNTHESIS
  a_summary_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && report_kind == KIND_SUMMARY) |-> end_of_run)
    else $error("summary without end of run");
  a_untagged_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && report_kind == KIND_MISMATCH && !is_pattern)
      |-> (source_index == '0 && displacement == '0))
    else $error("untagged report carries decoded fields");
`endif

endmodule

// ----- hdl/self_describing_pattern_checker.sv -----
// ----------------------------------------------------------------------------
// self_describing_pattern_checker
// Checks read-back halfwords against a tag-plus-index pattern.
// ----------------------------------------------------------------------------
// Takes one halfword per cycle while the job queue is not full. Each
// halfword is compared with 0x8000 plus its index modulo 32768; the first
// report_limit mismatches of a pass give a detailed report, and a halfword
// flagged last is followed by a summary. Counting is done in the front
// stage the cycle a request is taken; a four-entry job queue feeds the
// back stage, which emits one result per cycle into an output register
// while it is empty or popped. Results pass the job queue, then that
// register, to the result ports. An item with a report and a summary
// gives two results, so a run of such items fills the queue and stalls
// the front; other traffic runs at one item per cycle as results are taken.
// ----------------------------------------------------------------------------
module self_describing_pattern_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [spc_pkg::DATA_W-1:0]   read_data,
  input  logic                         first,
  input  logic                         last,
  input  logic                         push,
  output logic                         full,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [spc_pkg::LIMIT_W-1:0]  cfg_data,
  output logic                         empty,
  input  logic                         pop,
  output logic                         report_kind,
  output logic [spc_pkg::OFFSET_W-1:0] byte_offset,
  output logic [spc_pkg::DATA_W-1:0]   expected,
  output logic [spc_pkg::DATA_W-1:0]   observed,
  output logic                         is_pattern,
  output logic [spc_pkg::SRC_W-1:0]    source_index,
  output logic signed [spc_pkg::DISP_W-1:0] displacement,
  output logic [spc_pkg::COUNT_W-1:0]  mismatch_count,
  output logic [spc_pkg::COUNT_W-1:0]  checked_count,
  output logic                         end_of_run
);
  import spc_pkg::*;

  spc_job_t in_job, head_job;
  logic     in_push, q_full, q_valid, q_pop;

  // classify and count
  spc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .read_data (read_data),
    .first     (first),
    .last      (last),
    .push      (push),
    .full      (full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .job_push  (in_push),
    .job       (in_job),
    .job_full  (q_full)
  );

  // decouple front from back
  spc_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (in_push),
    .din   (in_job),
    .full  (q_full),
    .valid (q_valid),
    .dout  (head_job),
    .pop   (q_pop)
  );

  // emit results
  spc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (q_valid),
    .job            (head_job),
    .job_pop        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .report_kind    (report_kind),
    .byte_offset    (byte_offset),
    .expected       (expected),
    .observed       (observed),
    .is_pattern     (is_pattern),
    .source_index   (source_index),
    .displacement   (displacement),
    .mismatch_count (mismatch_count),
    .checked_count  (checked_count),
    .end_of_run     (end_of_run)
  );

endmodule
